### hdl/sbrr_pkg.sv
// Package with types and constants of the servo bus response receiver.
`timescale 1ns / 1ps
package sbrr_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned TicksW   = 20;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 20;

  localparam logic [ByteW-1:0]  HeaderByte  = 8'hff;
  localparam logic [ByteW-1:0]  MinLength   = 8'd2;
  localparam logic [TicksW-1:0] ElapsedMax  = '1;
  localparam logic [ByteW-1:0]  IdReset     = 8'd1;
  localparam logic [TicksW-1:0] TimeoutReset = 20'd10000;

  localparam int unsigned BitVoltage     = 0;
  localparam int unsigned BitOverheat    = 2;
  localparam int unsigned BitChecksum    = 4;
  localparam int unsigned BitOverload    = 5;
  localparam int unsigned BitInstruction = 6;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_EXPECTED_ID   = 1'd0,
    REG_TIMEOUT_TICKS = 1'd1
  } reg_e;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_ID   = 3'd2,
    PH_LEN  = 3'd3,
    PH_ERR  = 3'd4,
    PH_BODY = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    PEND_QUIET    = 2'd0,
    PEND_BAD_ID   = 2'd1,
    PEND_BAD_SIZE = 2'd2
  } pend_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_QUIET       = 3'd1,
    ST_BAD_ID      = 3'd2,
    ST_BAD_SIZE    = 3'd3,
    ST_BAD_CHECK   = 3'd4,
    ST_DEV_CHECK   = 3'd5,
    ST_DEV_INSTR   = 3'd6
  } status_e;

  typedef struct packed {
    logic             is_final;
    logic [ByteW-1:0] param_byte;
    status_e          status;
    logic             voltage_flag;
    logic             overheat_flag;
    logic             overload_flag;
    logic [ByteW-1:0] device_error;
  } res_t;

endpackage

### hdl/servo_bus_response_receiver_top.sv
// Top level of the servo bus response receiver: status packet parser.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries kind_i and rx_byte_i: a start
//   command, a received bus byte, or one time tick. Output channel (out_valid_o /
//   out_stall_i) carries one result: a parameter byte (is_final_o low) or the
//   final status of the reception. Parameter bytes are valid only if the final
//   status is ok. Configuration writes (cfg_valid_i / cfg_ready_o) set the
//   expected id (index 0) and the timeout in ticks (index 1); ready is always high.
//   A result appears at the output register in the cycle after the transfer
//   that causes it. Throughput: one item per cycle while in_stall_o is low;
//   the parser state and the output register are updated in the same cycle
//   from an 8-bit compare, an 8-bit add and a 20-bit tick compare.
//   Reset: no reception is open, expected id is 1, timeout is 10000 ticks; bytes
//   and ticks are ignored until a start command.
//   Stall: while the output register holds a result and the receiver stalls,
//   in_stall_o is high; a result being taken frees the register in the same
//   cycle, so input transfers continue without a gap.
module servo_bus_response_receiver_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    kind_i,
  input  logic [sbrr_pkg::ByteW-1:0]    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          is_final_o,
  output logic [sbrr_pkg::ByteW-1:0]    param_byte_o,
  output logic [2:0]                    status_o,
  output logic                          voltage_flag_o,
  output logic                          overheat_flag_o,
  output logic                          overload_flag_o,
  output logic [sbrr_pkg::ByteW-1:0]    device_error_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sbrr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sbrr_pkg::CfgDataW-1:0] cfg_data_i
);
  import sbrr_pkg::*;

  logic [ByteW-1:0]  expected_id_q;
  logic [TicksW-1:0] timeout_q;

  logic              active_q, active_d;
  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  param_total_q, param_total_d;
  logic [ByteW-1:0]  param_seen_q, param_seen_d;
  logic [ByteW-1:0]  sum_q, sum_d;
  logic [ByteW-1:0]  err_q, err_d;
  pend_e             pend_q, pend_d;
  logic [TicksW-1:0] elapsed_q, elapsed_d;

  logic              out_valid_q, out_valid_d;
  res_t              res_q, res_d;
  logic              res_vld;
  logic              acc;
  logic [ByteW-1:0]  want;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign acc         = in_valid_i && !in_stall_o;
  assign want        = ~sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_id_q <= IdReset;
      timeout_q     <= TimeoutReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_e'(cfg_index_i))
        REG_EXPECTED_ID:   expected_id_q <= cfg_data_i[ByteW-1:0];
        REG_TIMEOUT_TICKS: timeout_q     <= cfg_data_i[TicksW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    active_d      = active_q;
    phase_d       = phase_q;
    param_total_d = param_total_q;
    param_seen_d  = param_seen_q;
    sum_d         = sum_q;
    err_d         = err_q;
    pend_d        = pend_q;
    elapsed_d     = elapsed_q;
    res_vld       = 1'b0;
    res_d         = '0;
    res_d.status  = ST_OK;

    if (acc) begin
      if (kind_e'(kind_i) == KIND_START) begin
        active_d      = 1'b1;
        phase_d       = PH_HDR0;
        param_total_d = '0;
        param_seen_d  = '0;
        sum_d         = '0;
        err_d         = '0;
        pend_d        = PEND_QUIET;
        elapsed_d     = '0;
      end else if (active_q && kind_e'(kind_i) == KIND_BYTE) begin
        unique case (phase_q)
          PH_HDR0: phase_d = (rx_byte_i == HeaderByte) ? PH_HDR1 : PH_HDR0;
          PH_HDR1: phase_d = (rx_byte_i == HeaderByte) ? PH_ID : PH_HDR0;
          PH_ID: begin
            if (rx_byte_i == expected_id_q) begin
              sum_d   = rx_byte_i;
              phase_d = PH_LEN;
            end else begin
              pend_d  = PEND_BAD_ID;
              phase_d = PH_HDR0;
            end
          end
          PH_LEN: begin
            if (rx_byte_i >= MinLength) begin
              param_total_d = rx_byte_i - MinLength;
              param_seen_d  = '0;
              sum_d         = sum_q + rx_byte_i;
              phase_d       = PH_ERR;
            end else begin
              pend_d  = PEND_BAD_SIZE;
              phase_d = PH_HDR0;
            end
          end
          PH_ERR: begin
            err_d   = rx_byte_i;
            sum_d   = sum_q + rx_byte_i;
            phase_d = PH_BODY;
          end
          PH_BODY: begin
            res_vld = 1'b1;
            if (param_seen_q < param_total_q) begin
              param_seen_d     = param_seen_q + 8'd1;
              sum_d            = sum_q + rx_byte_i;
              res_d.param_byte = rx_byte_i;
            end else begin
              active_d           = 1'b0;
              res_d.is_final     = 1'b1;
              res_d.device_error = err_q;
              if (rx_byte_i != want) begin
                res_d.status = ST_BAD_CHECK;
              end else if (err_q[BitChecksum]) begin
                res_d.status = ST_DEV_CHECK;
              end else if (err_q[BitInstruction]) begin
                res_d.status = ST_DEV_INSTR;
              end else begin
                res_d.voltage_flag  = err_q[BitVoltage];
                res_d.overheat_flag = err_q[BitOverheat];
                res_d.overload_flag = err_q[BitOverload];
              end
            end
          end
          default: phase_d = PH_HDR0;
        endcase
      end else if (active_q && kind_e'(kind_i) == KIND_TICK) begin
        if (elapsed_q != ElapsedMax) begin
          elapsed_d = elapsed_q + 20'd1;
        end
        if (elapsed_d > timeout_q) begin
          active_d       = 1'b0;
          res_vld        = 1'b1;
          res_d.is_final = 1'b1;
          unique case (pend_q)
            PEND_BAD_ID:   res_d.status = ST_BAD_ID;
            PEND_BAD_SIZE: res_d.status = ST_BAD_SIZE;
            default:       res_d.status = ST_QUIET;
          endcase
        end
      end
    end

    out_valid_d = acc ? res_vld : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q      <= 1'b0;
      phase_q       <= PH_HDR0;
      param_total_q <= '0;
      param_seen_q  <= '0;
      sum_q         <= '0;
      err_q         <= '0;
      pend_q        <= PEND_QUIET;
      elapsed_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      active_q      <= active_d;
      phase_q       <= phase_d;
      param_total_q <= param_total_d;
      param_seen_q  <= param_seen_d;
      sum_q         <= sum_d;
      err_q         <= err_d;
      pend_q        <= pend_d;
      elapsed_q     <= elapsed_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // hold the result while stalled, load on a transfer that produces one
  always_ff @(posedge clk_i) begin
    if (acc && res_vld) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign is_final_o      = res_q.is_final;
  assign param_byte_o    = res_q.param_byte;
  assign status_o        = res_q.status;
  assign voltage_flag_o  = res_q.voltage_flag;
  assign overheat_flag_o = res_q.overheat_flag;
  assign overload_flag_o = res_q.overload_flag;
  assign device_error_o  = res_q.device_error;

`ifndef NO_ASSERTIONS
  a_final_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && res_vld && res_d.is_final |=> !active_q)
    else $error("final status did not close the reception");

  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    param_seen_q <= param_total_q)
    else $error("parameter count passed the packet length");

  a_param_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.is_final |->
      res_q.status == ST_OK && res_q.device_error == '0)
    else $error("parameter result carries status fields");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(acc && res_vld))
    else $error("result appeared without a transfer");
`endif

endmodule
